FILE: design/crlw_pkg.sv
// Shared types and constants for the capped restart loop watchdog.
package crlw_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // Item kinds
  localparam logic [KindW-1:0] KindTick   = 3'd0;
  localparam logic [KindW-1:0] KindBeat   = 3'd1;
  localparam logic [KindW-1:0] KindPause  = 3'd2;
  localparam logic [KindW-1:0] KindResume = 3'd3;
  localparam logic [KindW-1:0] KindArm    = 3'd4;
  localparam logic [KindW-1:0] KindAck    = 3'd5;
  localparam logic [KindW-1:0] KindReboot = 3'd6;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBudget = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMax    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgForget = 3'd3;

  // Configuration reset values
  localparam logic              EnableRst = 1'b1;
  localparam logic [TimeW-1:0]  BudgetRst = 32'd30000;
  localparam logic [CountW-1:0] MaxRst    = 4'd3;
  localparam logic [TimeW-1:0]  ForgetRst = 32'd300000;

  localparam logic [CountW-1:0] CountSat = 4'd15;

  typedef struct packed {
    logic [KindW-1:0] req_type;
    logic [TimeW-1:0] now_ms;
  } crlw_in_t;

  typedef struct packed {
    logic              restart_request;
    logic              trip_logged;
    logic              fresh_trip;
    logic [CountW-1:0] run_count;
    logic [TimeW-1:0]  quiet_ms;
    logic              was_restarted;
    logic              is_armed;
  } crlw_out_t;

  // Record is valid when marked and 1 <= count <= cap + 1
  function automatic logic rec_valid(input logic marked, input logic [CountW-1:0] count,
                                     input logic [CountW-1:0] trip_cap);
    logic [CountW:0] lim;
    lim = {1'b0, trip_cap} + {{CountW{1'b0}}, 1'b1};
    return marked && (count != '0) && ({1'b0, count} <= lim);
  endfunction

endpackage

FILE: design/capped_restart_loop_watchdog.sv
// The result of an item is presented the cycle after it is accepted.
// Throughput: one item per cycle unless the output stalls; the whole update is one
// subtract/compare pass between the watchdog state registers and the output register.
// A new item is accepted while the output register is empty or being drained.
// Reset: config returns to its defaults, state and trip record are cleared,
// pause nesting starts at one and the output register is empty.
module capped_restart_loop_watchdog #(
  parameter int unsigned NEST_WIDTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  crlw_pkg::crlw_in_t         in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output crlw_pkg::crlw_out_t        out_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [crlw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [crlw_pkg::CfgDatW-1:0] cfg_data_i
);
  import crlw_pkg::*;

  localparam logic [NEST_WIDTH-1:0] NestMax  = {NEST_WIDTH{1'b1}};
  localparam logic [NEST_WIDTH-1:0] NestBoot = NEST_WIDTH'(1);

  // Configuration
  logic              enable_q;
  logic [TimeW-1:0]  budget_q;
  logic [CountW-1:0] max_q;
  logic [TimeW-1:0]  forget_q;

  // Watchdog state
  logic [TimeW-1:0]      last_beat_q, last_beat_d;
  logic [NEST_WIDTH-1:0] nest_q, nest_d;
  logic                  armed_q, armed_d;
  logic                  gave_up_q, gave_up_d;
  logic [CountW-1:0]     boot_run_q, boot_run_d;
  logic                  marked_q, marked_d;
  logic [CountW-1:0]     rec_count_q, rec_count_d;
  logic [CountW-1:0]     reported_q, reported_d;
  logic [TimeW-1:0]      rec_quiet_q, rec_quiet_d;
  logic                  rec_restart_q, rec_restart_d;
  logic                  report_done_q, report_done_d;

  logic                  out_valid_q;
  crlw_out_t             out_q, out_d;

  logic                  accept;
  logic [TimeW-1:0]      quiet;
  logic [CountW:0]       max_p1;
  logic                  tick_valid;
  logic                  will;
  logic                  restart;
  logic                  logged;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign quiet  = in_i.now_ms - last_beat_q;
  assign max_p1 = {1'b0, max_q} + {{CountW{1'b0}}, 1'b1};

  always_comb begin
    last_beat_d   = last_beat_q;
    nest_d        = nest_q;
    armed_d       = armed_q;
    gave_up_d     = gave_up_q;
    boot_run_d    = boot_run_q;
    marked_d      = marked_q;
    rec_count_d   = rec_count_q;
    reported_d    = reported_q;
    rec_quiet_d   = rec_quiet_q;
    rec_restart_d = rec_restart_q;
    report_done_d = report_done_q;
    restart       = 1'b0;
    logged        = 1'b0;
    tick_valid    = 1'b0;
    will          = 1'b0;

    case (in_i.req_type)
      KindTick: begin
        if ((nest_q != '0) || !armed_q) begin
          last_beat_d = in_i.now_ms;
        end else begin
          // earlier-boot run is dropped once uptime passes the forget window
          if (!gave_up_q && (boot_run_q != '0) && (in_i.now_ms >= forget_q) &&
              rec_valid(marked_q, rec_count_q, max_q)) begin
            marked_d    = 1'b0;
            rec_count_d = '0;
            reported_d  = '0;
            boot_run_d  = '0;
          end
          if (quiet >= budget_q) begin
            tick_valid    = rec_valid(marked_d, rec_count_d, max_q);
            will          = !tick_valid || (rec_count_d < max_q);
            rec_quiet_d   = quiet;
            rec_restart_d = will;
            if (tick_valid) begin
              if (({1'b0, rec_count_d} < max_p1) && (rec_count_d < CountSat)) begin
                rec_count_d = rec_count_d + CountW'(1);
              end
            end else begin
              rec_count_d = CountW'(1);
            end
            marked_d   = 1'b1;
            reported_d = '0;
            logged     = 1'b1;
            if (will) begin
              restart = 1'b1;
            end else begin
              gave_up_d = 1'b1;
              armed_d   = 1'b0;
            end
          end
        end
      end
      KindBeat: begin
        last_beat_d = in_i.now_ms;
      end
      KindPause: begin
        if (nest_q != NestMax) nest_d = nest_q + NEST_WIDTH'(1);
        last_beat_d = in_i.now_ms;
      end
      KindResume: begin
        if (nest_q != '0) nest_d = nest_q - NEST_WIDTH'(1);
        last_beat_d = in_i.now_ms;
      end
      KindArm: begin
        if (enable_q && !armed_q) begin
          boot_run_d  = rec_valid(marked_q, rec_count_q, max_q) ? rec_count_q : '0;
          last_beat_d = in_i.now_ms;
          armed_d     = 1'b1;
          gave_up_d   = 1'b0;
          nest_d      = '0;
        end
      end
      KindAck: begin
        if (!report_done_q && rec_valid(marked_q, rec_count_q, max_q) &&
            (reported_q != rec_count_q)) begin
          report_done_d = 1'b1;
          reported_d    = rec_count_q;
        end
      end
      KindReboot: begin
        // record and reported count survive the reboot
        last_beat_d   = '0;
        nest_d        = NestBoot;
        armed_d       = 1'b0;
        gave_up_d     = 1'b0;
        boot_run_d    = '0;
        report_done_d = 1'b0;
      end
      default: begin
      end
    endcase

    out_d.restart_request = restart;
    out_d.trip_logged     = logged;
    out_d.fresh_trip      = rec_valid(marked_d, rec_count_d, max_q) &&
                            (reported_d != rec_count_d);
    out_d.run_count       = rec_count_d;
    out_d.quiet_ms        = rec_quiet_d;
    out_d.was_restarted   = rec_restart_d;
    out_d.is_armed        = armed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= EnableRst;
      budget_q <= BudgetRst;
      max_q    <= MaxRst;
      forget_q <= ForgetRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgEnable: enable_q <= cfg_data_i[0];
        CfgBudget: budget_q <= cfg_data_i[TimeW-1:0];
        CfgMax:    max_q    <= cfg_data_i[CountW-1:0];
        CfgForget: forget_q <= cfg_data_i[TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_beat_q   <= '0;
      nest_q        <= NestBoot;
      armed_q       <= 1'b0;
      gave_up_q     <= 1'b0;
      boot_run_q    <= '0;
      marked_q      <= 1'b0;
      rec_count_q   <= '0;
      reported_q    <= '0;
      rec_quiet_q   <= '0;
      rec_restart_q <= 1'b0;
      report_done_q <= 1'b0;
    end else if (accept) begin
      last_beat_q   <= last_beat_d;
      nest_q        <= nest_d;
      armed_q       <= armed_d;
      gave_up_q     <= gave_up_d;
      boot_run_q    <= boot_run_d;
      marked_q      <= marked_d;
      rec_count_q   <= rec_count_d;
      reported_q    <= reported_d;
      rec_quiet_q   <= rec_quiet_d;
      rec_restart_q <= rec_restart_d;
      report_done_q <= report_done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  // Every accepted item leaves a result in the output register
  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  // A restart is only requested together with a new trip record
  a_restart_logged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.restart_request |-> out_o.trip_logged && out_o.was_restarted)
    else $error("restart request without trip record");

  // A trip that gives up leaves the supervisor disarmed
  a_giveup_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.trip_logged && !out_o.restart_request |-> !out_o.is_armed)
    else $error("gave up but still armed");

endmodule
